FILE: rtl/cist_pkg.sv
`default_nettype none

package cist_pkg;

    localparam int OP_W   = 3;
    localparam int ID_W   = 64;
    localparam int POS_W  = 11;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 10;
    localparam int FLAT_W = 11;
    localparam int EPC_W  = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_FIRST  = 3'd3;
    localparam logic [OP_W-1:0] OP_NEXT   = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_NONE     = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_INTERNAL = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OPEN,
        S_PICK,
        S_PICK_CHK,
        S_FIND,
        S_FIND_CHK,
        S_WRITE,
        S_SCAN,
        S_SCAN_CHK,
        S_DEL,
        S_PUT
    } fsm_t;

endpackage

`default_nettype wire

FILE: rtl/cist_if.sv
`default_nettype none

interface cist_req_if;
    logic                        valid;
    logic                        ready;
    logic [cist_pkg::OP_W-1:0]   op;
    logic [cist_pkg::ID_W-1:0]   id_value;
    logic [cist_pkg::POS_W-1:0]  position;

    modport source (output valid, op, id_value, position, input ready);
    modport sink (input valid, op, id_value, position, output ready);
endinterface

interface cist_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [cist_pkg::STAT_W-1:0]  status;
    logic                         found;
    logic [cist_pkg::SLOT_W-1:0]  slot_index;
    logic [cist_pkg::ID_W-1:0]    id_out;
    logic [cist_pkg::POS_W-1:0]   next_position;
    logic [cist_pkg::FLAT_W-1:0]  id_total;

    modport source (output valid, status, found, slot_index, id_out, next_position, id_total,
                    input ready);
    modport sink (input valid, status, found, slot_index, id_out, next_position, id_total,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/cist_ram.sv
`default_nettype none

module cist_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 64
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/chunked_id_set_table.sv
`default_nettype none

// Channel   Direction  Word carries
// req       in         op, id_value, position
// rsp       out        status, found, slot_index, id_out, next_position, id_total
// cfg       in         entries_per_chunk write (cfg_we, cfg_wdata)
//
// One word at a time. Insert zeroes each slot of a chunk that it opens, one slot at a time, and
// when it searches for a free slot it reads and then checks one slot at a time. Lookup, delete,
// first and next read and then check the slot memory one slot at a time from the start of the
// set, as the single slot memory port allows.
// Reset empties the set at once; the memory is zeroed chunk by chunk as chunks open.
// A result waits in the output register while the next word is accepted.

module chunked_id_set_table #(
    parameter int MAX_CHUNKS          = 16,
    parameter int MAX_SLOTS_PER_CHUNK = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    cist_req_if.sink                           req,
    cist_rsp_if.source                         rsp,
    input  wire logic                          cfg_we,
    input  wire logic [cist_pkg::EPC_W-1:0]    cfg_wdata
);

    import cist_pkg::*;

    localparam int CW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int SW  = (MAX_SLOTS_PER_CHUNK > 1) ? $clog2(MAX_SLOTS_PER_CHUNK) : 1;
    localparam int CNW = $clog2(MAX_CHUNKS + 1);
    localparam int AW  = CW + SW;

    fsm_t               state_reg, state_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CW-1:0]      c_reg, c_next;
    logic [SW-1:0]      s_reg, s_next;
    logic [FLAT_W-1:0]  f_reg, f_next;
    logic [CNW-1:0]     chunks_reg, chunks_next;
    logic [EPC_W-1:0]   free_reg, free_next;
    logic [SW-1:0]      high_reg, high_next;
    logic [FLAT_W-1:0]  base_reg, base_next;
    logic [FLAT_W-1:0]  held_reg, held_next;
    logic [EPC_W-1:0]   epc_reg, epc_next;

    status_t            rstat_reg, rstat_next;
    logic               rfound_reg, rfound_next;
    logic [SLOT_W-1:0]  rslot_reg, rslot_next;
    logic [ID_W-1:0]    rid_reg, rid_next;
    logic [POS_W-1:0]   rnpos_reg, rnpos_next;

    logic               ovalid_reg, ovalid_next;
    logic [STAT_W-1:0]  ostat_reg, ostat_next;
    logic               ofound_reg, ofound_next;
    logic [SLOT_W-1:0]  oslot_reg, oslot_next;
    logic [ID_W-1:0]    oid_reg, oid_next;
    logic [POS_W-1:0]   onpos_reg, onpos_next;
    logic [FLAT_W-1:0]  ototal_reg, ototal_next;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_addr;
    logic [ID_W-1:0]    ram_wdata, ram_rdata;

    logic               accept, out_free;
    logic [FLAT_W-1:0]  e_f, s_f, high_f, wval;
    logic [CW-1:0]      c_last;
    logic [SW-1:0]      s_sel;
    logic               s_end, c_end, hit;

    assign accept   = req.valid && req.ready;
    assign out_free = !ovalid_reg || rsp.ready;
    assign e_f      = FLAT_W'(epc_reg);
    assign s_f      = FLAT_W'(s_reg);
    assign high_f   = FLAT_W'(high_reg);
    assign c_last   = CW'(chunks_reg - CNW'(1));
    assign s_end    = (s_f == e_f - FLAT_W'(1));
    assign c_end    = (c_reg == c_last);
    assign wval     = FLAT_W'(cfg_wdata);

    always_comb
    begin
        if (free_reg == epc_reg)
        begin
            s_sel = '0;
        end
        else if (high_f + FLAT_W'(1) < e_f)
        begin
            s_sel = SW'(high_f + FLAT_W'(1));
        end
        else
        begin
            s_sel = '0;
        end
    end

    always_comb
    begin
        if (op_reg == OP_LOOKUP || op_reg == OP_DELETE)
        begin
            hit = (ram_rdata == id_reg);
        end
        else
        begin
            hit = (ram_rdata != '0) && (op_reg == OP_FIRST || f_reg >= pos_reg);
        end
    end

    cist_ram #(
        .ADDR_W (AW),
        .DATA_W (ID_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PUT;
                    if (req.op == OP_INSERT && req.id_value != '0)
                    begin
                        if (chunks_reg == '0 || free_reg == '0)
                        begin
                            if (chunks_reg != CNW'(MAX_CHUNKS))
                            begin
                                state_next = S_OPEN;
                            end
                        end
                        else
                        begin
                            state_next = S_PICK;
                        end
                    end
                    else if ((req.op == OP_LOOKUP || req.op == OP_DELETE)
                             && req.id_value != '0 && chunks_reg != '0)
                    begin
                        state_next = S_SCAN;
                    end
                    else if ((req.op == OP_FIRST || (req.op == OP_NEXT && req.position != '0))
                             && chunks_reg != '0)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_OPEN:
            begin
                if (s_end)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (free_reg == epc_reg)
                begin
                    state_next = S_WRITE;
                end
                else if (high_f + FLAT_W'(1) < e_f)
                begin
                    state_next = S_PICK_CHK;
                end
                else
                begin
                    state_next = S_FIND;
                end
            end
            S_PICK_CHK:
            begin
                state_next = (ram_rdata != '0) ? S_PUT : S_WRITE;
            end
            S_FIND:
            begin
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK:
            begin
                if (ram_rdata == '0)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = s_end ? S_PUT : S_FIND;
                end
            end
            S_WRITE:
            begin
                state_next = S_PUT;
            end
            S_SCAN:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (hit)
                begin
                    state_next = (op_reg == OP_DELETE) ? S_DEL : S_PUT;
                end
                else
                begin
                    state_next = (s_end && c_end) ? S_PUT : S_SCAN;
                end
            end
            S_DEL:
            begin
                state_next = S_PUT;
            end
            S_PUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory and handshake controls.
    always_comb
    begin
        req.ready = (state_reg == S_IDLE);
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = {c_reg, s_reg};
        ram_wdata = '0;
        unique case (state_reg)
            S_OPEN:
            begin
                ram_we = 1'b1;
            end
            S_PICK:
            begin
                ram_re   = 1'b1;
                ram_addr = {c_reg, s_sel};
            end
            S_FIND, S_SCAN:
            begin
                ram_re = 1'b1;
            end
            S_WRITE:
            begin
                ram_we    = 1'b1;
                ram_wdata = id_reg;
            end
            S_DEL:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        op_next     = op_reg;
        id_next     = id_reg;
        pos_next    = pos_reg;
        c_next      = c_reg;
        s_next      = s_reg;
        f_next      = f_reg;
        chunks_next = chunks_reg;
        free_next   = free_reg;
        high_next   = high_reg;
        base_next   = base_reg;
        held_next   = held_reg;
        epc_next    = epc_reg;
        rstat_next  = rstat_reg;
        rfound_next = rfound_reg;
        rslot_next  = rslot_reg;
        rid_next    = rid_reg;
        rnpos_next  = rnpos_reg;
        ovalid_next = ovalid_reg;
        ostat_next  = ostat_reg;
        ofound_next = ofound_reg;
        oslot_next  = oslot_reg;
        oid_next    = oid_reg;
        onpos_next  = onpos_reg;
        ototal_next = ototal_reg;

        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        if (cfg_we)
        begin
            if (wval == '0)
            begin
                epc_next = EPC_W'(1);
            end
            else if (wval > FLAT_W'(MAX_SLOTS_PER_CHUNK))
            begin
                epc_next = EPC_W'(MAX_SLOTS_PER_CHUNK);
            end
            else
            begin
                epc_next = cfg_wdata;
            end
            chunks_next = '0;
            held_next   = '0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = req.op;
                    id_next     = req.id_value;
                    pos_next    = req.position;
                    rstat_next  = STAT_NONE;
                    rfound_next = 1'b0;
                    rslot_next  = '0;
                    rid_next    = '0;
                    rnpos_next  = '0;
                    c_next      = '0;
                    s_next      = '0;
                    f_next      = '0;
                    if (req.op == OP_INSERT && req.id_value != '0)
                    begin
                        if (chunks_reg == '0 || free_reg == '0)
                        begin
                            if (chunks_reg == CNW'(MAX_CHUNKS))
                            begin
                                rstat_next = STAT_FULL;
                            end
                            else
                            begin
                                c_next = CW'(chunks_reg);
                            end
                        end
                        else
                        begin
                            c_next = c_last;
                        end
                    end
                    else if (req.op == OP_CLEAR)
                    begin
                        chunks_next = '0;
                        held_next   = '0;
                        rstat_next  = STAT_OK;
                    end
                end
            end
            S_OPEN:
            begin
                s_next = s_reg + SW'(1);
                if (s_end)
                begin
                    chunks_next = chunks_reg + CNW'(1);
                    free_next   = epc_reg;
                    high_next   = '0;
                    base_next   = (chunks_reg == '0) ? '0 : base_reg + e_f;
                end
            end
            S_PICK:
            begin
                s_next = s_sel;
            end
            S_PICK_CHK:
            begin
                if (ram_rdata != '0)
                begin
                    rstat_next = STAT_INTERNAL;
                end
            end
            S_FIND_CHK:
            begin
                if (ram_rdata != '0)
                begin
                    if (s_end)
                    begin
                        rstat_next = STAT_INTERNAL;
                    end
                    else
                    begin
                        s_next = s_reg + SW'(1);
                    end
                end
            end
            S_WRITE:
            begin
                held_next  = held_reg + FLAT_W'(1);
                rstat_next = STAT_OK;
                rslot_next = SLOT_W'(base_reg + s_f);
                if (free_reg != '0)
                begin
                    free_next = free_reg - EPC_W'(1);
                end
                if (s_reg > high_reg)
                begin
                    high_next = s_reg;
                end
            end
            S_SCAN_CHK:
            begin
                if (hit)
                begin
                    rstat_next = STAT_OK;
                    if (op_reg == OP_LOOKUP || op_reg == OP_DELETE)
                    begin
                        rfound_next = 1'b1;
                    end
                    else
                    begin
                        rid_next   = ram_rdata;
                        rnpos_next = f_reg + FLAT_W'(1);
                    end
                end
                else
                begin
                    f_next = f_reg + FLAT_W'(1);
                    if (s_end)
                    begin
                        s_next = '0;
                        c_next = c_reg + CW'(1);
                    end
                    else
                    begin
                        s_next = s_reg + SW'(1);
                    end
                end
            end
            S_DEL:
            begin
                if (held_reg != '0)
                begin
                    held_next = held_reg - FLAT_W'(1);
                end
            end
            S_PUT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = rstat_reg;
                    ofound_next = rfound_reg;
                    oslot_next  = rslot_reg;
                    oid_next    = rid_reg;
                    onpos_next  = rnpos_reg;
                    ototal_next = held_reg;
                end
            end
            default:
            begin
                f_next = f_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            chunks_reg <= '0;
            free_reg   <= '0;
            high_reg   <= '0;
            base_reg   <= '0;
            held_reg   <= '0;
            epc_reg    <= EPC_W'(MAX_SLOTS_PER_CHUNK);
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            chunks_reg <= chunks_next;
            free_reg   <= free_next;
            high_reg   <= high_next;
            base_reg   <= base_next;
            held_reg   <= held_next;
            epc_reg    <= epc_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        pos_reg    <= pos_next;
        c_reg      <= c_next;
        s_reg      <= s_next;
        f_reg      <= f_next;
        rstat_reg  <= rstat_next;
        rfound_reg <= rfound_next;
        rslot_reg  <= rslot_next;
        rid_reg    <= rid_next;
        rnpos_reg  <= rnpos_next;
        ostat_reg  <= ostat_next;
        ofound_reg <= ofound_next;
        oslot_reg  <= oslot_next;
        oid_reg    <= oid_next;
        onpos_reg  <= onpos_next;
        ototal_reg <= ototal_next;
    end

    assign rsp.valid         = ovalid_reg;
    assign rsp.status        = ostat_reg;
    assign rsp.found         = ofound_reg;
    assign rsp.slot_index    = oslot_reg;
    assign rsp.id_out        = oid_reg;
    assign rsp.next_position = onpos_reg;
    assign rsp.id_total      = ototal_reg;

`ifndef SYNTHESIS
    a_write_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && !cfg_we) |=> (held_reg == $past(held_reg) + FLAT_W'(1)))
        else $error("insert did not count the new word");

    a_chunks_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chunks_reg <= CNW'(MAX_CHUNKS))
        else $error("more chunks opened than exist");

    a_read_before_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK_CHK || state_reg == S_FIND_CHK || state_reg == S_SCAN_CHK)
        |-> $past(ram_re))
        else $error("memory data checked without a read");
`endif

endmodule

`default_nettype wire
